>>> hw/rtl/ttq_pkg.sv
// Shared types, codes and helpers for the thread table with free list and ready queues.
// Used by ttq_front, ttq_back and thread_table_free_list_ready_queues.
package ttq_pkg;

  localparam int SLOT_COUNT_DEF     = 1024;
  localparam int CPU_COUNT_DEF      = 4;
  localparam int PRIORITY_COUNT_DEF = 8;

  typedef enum logic [2:0] {
    MODE_ALLOC    = 3'd0,
    MODE_FREE     = 3'd1,
    MODE_LOOKUP   = 3'd2,
    MODE_ADMIT    = 3'd3,
    MODE_DISPATCH = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_FREE  = 2'd1,
    ST_NOT_USED = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    BK_CLEAR = 2'd0,
    BK_IDLE  = 2'd1,
    BK_EXEC  = 2'd2
  } bk_state_t;

  // An item after classification: operands wrapped, slot range checked.
  typedef struct packed {
    mode_t       mode;
    logic [1:0]  cpu;
    logic [2:0]  prio;
    logic [9:0]  slot_id;
    logic        sid_ok;
  } item_t;

  typedef struct packed {
    logic clearing;
    logic exec;
  } bk_status_t;

  // Reduces a small value below limit by repeated subtraction.
  function automatic logic [7:0] wrap_small(input logic [7:0] v, input int limit);
    logic [7:0] r;
    r = v;
    for (int i = 0; i < 8; i++) begin
      if (int'(r) >= limit) begin
        r = r - 8'(limit);
      end
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/ttq_front.sv
// Front end: accepts items, wraps operands, checks the slot range and queues
// them in a two-entry buffer for the back end. Depends on ttq_pkg.
module ttq_front import ttq_pkg::*; #(
  parameter int SLOT_COUNT     = SLOT_COUNT_DEF,
  parameter int CPU_COUNT      = CPU_COUNT_DEF,
  parameter int PRIORITY_COUNT = PRIORITY_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_mode,
  input  logic [1:0]  in_cpu,
  input  logic [2:0]  in_priority_req,
  input  logic [9:0]  in_slot_id,
  input  logic        item_pop,
  output logic        item_valid,
  output item_t       item
);

  item_t      buf_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  item_t      cls;

  assign in_stall   = (cnt_r == 2'd2);
  assign push       = in_valid && !in_stall;
  assign item_valid = (cnt_r != 2'd0);
  assign item       = buf_r[rd_ptr_r];

  always_comb begin
    cls.mode    = mode_t'(in_mode);
    cls.cpu     = 2'(wrap_small(8'(in_cpu), CPU_COUNT));
    cls.prio    = 3'(wrap_small(8'(in_priority_req), PRIORITY_COUNT));
    cls.slot_id = in_slot_id;
    cls.sid_ok  = (32'(in_slot_id) < 32'(SLOT_COUNT));
  end

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = item_pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(item_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_ptr_r] <= cls;
    end
  end

endmodule

>>> hw/rtl/ttq_back.sv
// Back end: slot table memories, free list and ready queue pointers, and the
// output register. Depends on ttq_pkg.
module ttq_back import ttq_pkg::*; #(
  parameter int SLOT_COUNT     = SLOT_COUNT_DEF,
  parameter int CPU_COUNT      = CPU_COUNT_DEF,
  parameter int PRIORITY_COUNT = PRIORITY_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        item_valid,
  input  item_t       item,
  output logic        item_pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [9:0]  out_result_slot,
  output logic [1:0]  out_result_cpu,
  output logic [2:0]  out_result_priority,
  output bk_status_t  bk_status
);

  localparam int SW   = $clog2(SLOT_COUNT);
  localparam int LW   = $clog2(SLOT_COUNT + 1);
  localparam int QN   = CPU_COUNT * PRIORITY_COUNT;
  localparam int QW   = (QN > 1) ? $clog2(QN) : 1;
  localparam int CW   = (CPU_COUNT > 4) ? $clog2(CPU_COUNT) : 2;
  localparam int IDLE = (CPU_COUNT < SLOT_COUNT) ? CPU_COUNT : SLOT_COUNT;
  localparam logic [LW-1:0] NIL = LW'(SLOT_COUNT);

  // Slot table memories.
  logic          use_mem   [SLOT_COUNT];
  logic [CW-1:0] cpu_mem   [SLOT_COUNT];
  logic [2:0]    prio_mem  [SLOT_COUNT];
  logic [LW-1:0] flink_mem [SLOT_COUNT];
  logic [LW-1:0] rlink_mem [SLOT_COUNT];

  logic          use_rd_r;
  logic [CW-1:0] cpu_rd_r;
  logic [2:0]    prio_rd_r;
  logic [LW-1:0] flink_rd_r;
  logic [LW-1:0] rlink_rd_r;

  bk_state_t     state_r, state_nxt;
  logic [SW-1:0] clr_cnt_r, clr_cnt_nxt;
  item_t         it_r;

  logic [LW-1:0] free_head_r, free_head_nxt;
  logic [LW-1:0] free_tail_r, free_tail_nxt;
  logic [LW-1:0] qhead_r [QN];
  logic [LW-1:0] qtail_r [QN];

  logic          qh_we, qt_we;
  logic [QW-1:0] qh_idx, qt_idx;
  logic [LW-1:0] qh_val, qt_val;

  logic          m_we;
  logic [SW-1:0] m_addr;
  logic          m_use;
  logic [CW-1:0] m_cpu;
  logic [2:0]    m_prio;
  logic          f_we;
  logic [SW-1:0] f_addr;
  logic [LW-1:0] f_data;
  logic          r_we;
  logic [SW-1:0] r_addr;
  logic [LW-1:0] r_data;

  logic [SW-1:0] m_raddr, f_raddr, r_raddr;

  logic          out_valid_r, out_valid_nxt;
  logic [1:0]    out_status_r, out_status_nxt;
  logic [9:0]    out_slot_r, out_slot_nxt;
  logic [1:0]    out_cpu_r, out_cpu_nxt;
  logic [2:0]    out_prio_r, out_prio_nxt;

  logic [31:0]   sid_pop32, sid_it32, res32, clr32;
  logic [QW-1:0] q_pop, q_it, q_adm;
  logic [LW-1:0] qh_pop, qh_it, qt_adm, s_it, nx;
  logic          used;
  logic [LW-1:0] res_s;
  logic [CW-1:0] res_c;
  logic [2:0]    res_p;
  status_t       st;

  assign item_pop = (state_r == BK_IDLE) && item_valid && (!out_valid_r || !out_stall);

  assign sid_pop32 = 32'(item.slot_id);
  assign sid_it32  = 32'(it_r.slot_id);
  assign clr32     = 32'(clr_cnt_r);
  assign q_pop     = QW'(32'(item.cpu) * 32'(PRIORITY_COUNT) + 32'(item.prio));
  assign q_it      = QW'(32'(it_r.cpu) * 32'(PRIORITY_COUNT) + 32'(it_r.prio));
  assign q_adm     = QW'(32'(cpu_rd_r) * 32'(PRIORITY_COUNT) + 32'(prio_rd_r));
  assign qh_pop    = qhead_r[q_pop];
  assign qh_it     = qhead_r[q_it];
  assign qt_adm    = qtail_r[q_adm];
  assign s_it      = LW'(sid_it32);
  assign used      = it_r.sid_ok && use_rd_r;

  // Dispatch looks at the queue head; every other mode at the item's slot.
  assign m_raddr = (item.mode == MODE_DISPATCH) ? qh_pop[SW-1:0] : sid_pop32[SW-1:0];
  assign f_raddr = free_head_r[SW-1:0];
  assign r_raddr = qh_pop[SW-1:0];

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    free_head_nxt = free_head_r;
    free_tail_nxt = free_tail_r;
    qh_we = 1'b0; qh_idx = q_it; qh_val = NIL;
    qt_we = 1'b0; qt_idx = q_it; qt_val = NIL;
    m_we = 1'b0; m_addr = sid_it32[SW-1:0]; m_use = 1'b0; m_cpu = '0; m_prio = '0;
    f_we = 1'b0; f_addr = free_tail_r[SW-1:0]; f_data = s_it;
    r_we = 1'b0; r_addr = sid_it32[SW-1:0]; r_data = NIL;
    st    = ST_OK;
    res_s = '0;
    res_c = '0;
    res_p = '0;
    nx    = NIL;

    case (state_r)
      BK_CLEAR: begin
        m_we   = 1'b1;
        m_addr = clr_cnt_r;
        m_use  = (clr32 < 32'(IDLE));
        m_cpu  = m_use ? CW'(clr32) : '0;
        f_we   = 1'b1;
        f_addr = clr_cnt_r;
        f_data = LW'(clr32 + 32'd1);
        r_we   = 1'b1;
        r_addr = clr_cnt_r;
        if (clr32 == 32'(SLOT_COUNT - 1)) begin
          state_nxt = BK_IDLE;
        end else begin
          clr_cnt_nxt = clr_cnt_r + SW'(1);
        end
      end
      BK_IDLE: begin
        if (item_pop) begin
          state_nxt = BK_EXEC;
        end
      end
      BK_EXEC: begin
        state_nxt = BK_IDLE;
        case (it_r.mode)
          MODE_ALLOC: begin
            if (free_head_r == NIL) begin
              st = ST_NO_FREE;
            end else begin
              // The tail's link is stale; a single-entry list empties here.
              nx = (free_head_r == free_tail_r) ? NIL : flink_rd_r;
              free_head_nxt = nx;
              if (nx == NIL) begin
                free_tail_nxt = NIL;
              end
              m_we   = 1'b1;
              m_addr = free_head_r[SW-1:0];
              m_use  = 1'b1;
              m_cpu  = CW'(it_r.cpu);
              m_prio = it_r.prio;
              r_we   = 1'b1;
              r_addr = free_head_r[SW-1:0];
              res_s  = free_head_r;
              res_c  = CW'(it_r.cpu);
              res_p  = it_r.prio;
            end
          end
          MODE_FREE: begin
            if (!used) begin
              st = ST_NOT_USED;
            end else begin
              m_we   = 1'b1;
              m_use  = 1'b0;
              m_cpu  = cpu_rd_r;
              m_prio = prio_rd_r;
              if (free_tail_r == NIL || free_head_r == NIL) begin
                free_head_nxt = s_it;
              end else begin
                f_we = 1'b1;
              end
              free_tail_nxt = s_it;
            end
          end
          MODE_LOOKUP: begin
            if (!used) begin
              st = ST_NOT_USED;
            end else begin
              res_s = s_it;
              res_c = cpu_rd_r;
              res_p = prio_rd_r;
            end
          end
          MODE_ADMIT: begin
            if (!used) begin
              st = ST_NOT_USED;
            end else begin
              if (qt_adm == NIL) begin
                qh_we  = 1'b1;
                qh_idx = q_adm;
                qh_val = s_it;
              end else begin
                r_we   = 1'b1;
                r_addr = qt_adm[SW-1:0];
                r_data = s_it;
              end
              qt_we  = 1'b1;
              qt_idx = q_adm;
              qt_val = s_it;
            end
          end
          MODE_DISPATCH: begin
            if (qh_it == NIL) begin
              st = ST_EMPTY;
            end else begin
              qh_we  = 1'b1;
              qh_val = rlink_rd_r;
              if (rlink_rd_r == NIL) begin
                qt_we = 1'b1;
              end
              r_we   = 1'b1;
              r_addr = qh_it[SW-1:0];
              res_s  = qh_it;
              res_c  = cpu_rd_r;
              res_p  = prio_rd_r;
            end
          end
          default: begin
            st = ST_OK;
          end
        endcase
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  assign res32 = 32'(res_s);

  always_comb begin
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    out_cpu_nxt    = out_cpu_r;
    out_prio_nxt   = out_prio_r;
    if (state_r == BK_EXEC) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = st;
      out_slot_nxt   = res32[9:0];
      out_cpu_nxt    = res_c[1:0];
      out_prio_nxt   = res_p;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      free_head_r <= (IDLE < SLOT_COUNT) ? LW'(IDLE) : NIL;
      free_tail_r <= (IDLE < SLOT_COUNT) ? LW'(SLOT_COUNT - 1) : NIL;
      for (int k = 0; k < QN; k++) begin
        if ((k % PRIORITY_COUNT) == 0 && (k / PRIORITY_COUNT) < IDLE) begin
          qhead_r[k] <= LW'(k / PRIORITY_COUNT);
          qtail_r[k] <= LW'(k / PRIORITY_COUNT);
        end else begin
          qhead_r[k] <= NIL;
          qtail_r[k] <= NIL;
        end
      end
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      free_head_r <= free_head_nxt;
      free_tail_r <= free_tail_nxt;
      if (qh_we) begin
        qhead_r[qh_idx] <= qh_val;
      end
      if (qt_we) begin
        qtail_r[qt_idx] <= qt_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_cpu_r    <= out_cpu_nxt;
    out_prio_r   <= out_prio_nxt;
    if (item_pop) begin
      it_r <= item;
    end
  end

  always_ff @(posedge clk) begin
    use_rd_r   <= use_mem[m_raddr];
    cpu_rd_r   <= cpu_mem[m_raddr];
    prio_rd_r  <= prio_mem[m_raddr];
    flink_rd_r <= flink_mem[f_raddr];
    rlink_rd_r <= rlink_mem[r_raddr];
    if (m_we) begin
      use_mem[m_addr]  <= m_use;
      cpu_mem[m_addr]  <= m_cpu;
      prio_mem[m_addr] <= m_prio;
    end
    if (f_we) begin
      flink_mem[f_addr] <= f_data;
    end
    if (r_we) begin
      rlink_mem[r_addr] <= r_data;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_result_slot     = out_slot_r;
  assign out_result_cpu      = out_cpu_r;
  assign out_result_priority = out_prio_r;
  assign bk_status.clearing  = (state_r == BK_CLEAR);
  assign bk_status.exec      = (state_r == BK_EXEC);

endmodule

>>> hw/rtl/thread_table_free_list_ready_queues.sv
// Top level of the thread table with free list and ready queues.
// Depends on ttq_pkg, ttq_front and ttq_back.
//
// Input channel: in_valid/in_stall with in_mode, in_cpu, in_priority_req and
// in_slot_id. An item is taken at a clock edge with in_valid high and
// in_stall low. Result channel: out_valid/out_stall with out_status,
// out_result_slot, out_result_cpu and out_result_priority; every item gives
// exactly one result, in order.
// The front end holds up to two items. The back end takes no new item while one
// is in progress: in its idle state it reads the slot table and link memories
// for the item it takes, then its execute state writes the links back and loads
// the output register.
// After reset the back end initializes the slot table, one slot a cycle; items
// are buffered but not executed until then.
// When out_stall is high the result holds, the back end stops after the
// item in progress, and in_stall rises once the two-entry buffer is full.
module thread_table_free_list_ready_queues import ttq_pkg::*; #(
  parameter int SLOT_COUNT     = SLOT_COUNT_DEF,
  parameter int CPU_COUNT      = CPU_COUNT_DEF,
  parameter int PRIORITY_COUNT = PRIORITY_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_mode,
  input  logic [1:0]  in_cpu,
  input  logic [2:0]  in_priority_req,
  input  logic [9:0]  in_slot_id,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [9:0]  out_result_slot,
  output logic [1:0]  out_result_cpu,
  output logic [2:0]  out_result_priority
);

  logic       item_pop;
  logic       item_valid;
  item_t      item;
  bk_status_t bk_status;

  ttq_front #(
    .SLOT_COUNT     (SLOT_COUNT),
    .CPU_COUNT      (CPU_COUNT),
    .PRIORITY_COUNT (PRIORITY_COUNT)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_mode         (in_mode),
    .in_cpu          (in_cpu),
    .in_priority_req (in_priority_req),
    .in_slot_id      (in_slot_id),
    .item_pop        (item_pop),
    .item_valid      (item_valid),
    .item            (item)
  );

  ttq_back #(
    .SLOT_COUNT     (SLOT_COUNT),
    .CPU_COUNT      (CPU_COUNT),
    .PRIORITY_COUNT (PRIORITY_COUNT)
  ) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .item_valid          (item_valid),
    .item                (item),
    .item_pop            (item_pop),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_result_slot     (out_result_slot),
    .out_result_cpu      (out_result_cpu),
    .out_result_priority (out_result_priority),
    .bk_status           (bk_status)
  );

  // No result may appear while the table is still being initialized.
  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    bk_status.clearing |-> !out_valid)
    else $error("result during table initialization");

  // Execution does not repeat back to back and always produces a valid result.
  a_exec_result: assert property (@(posedge clk) disable iff (!rst_n)
    bk_status.exec |=> (!bk_status.exec && out_valid))
    else $error("execution did not produce a result");

  // The back end only takes an item the front end really holds.
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    item_pop |-> (item_valid && !bk_status.clearing))
    else $error("item taken from an empty buffer");

endmodule

>>> sim/tb_thread_table_free_list_ready_queues.sv
// Testbench for thread_table_free_list_ready_queues: a scoreboard that mirrors
// the slot table, free list and ready queues. Depends on ttq_pkg and the block.
module tb_thread_table_free_list_ready_queues;
  import ttq_pkg::*;

  localparam int NSLOT = 1024;
  localparam int NQ = 32;
  localparam logic [10:0] NIL = 11'd1024;

  typedef struct packed {
    logic [2:0] mode;
    logic [1:0] cpu;
    logic [2:0] prio;
    logic [9:0] slot;
  } op_item_t;

  typedef struct packed {
    status_t    status;
    logic [9:0] slot;
    logic [1:0] cpu;
    logic [2:0] prio;
  } op_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] in_mode = '0;
  logic [1:0] in_cpu = '0;
  logic [2:0] in_priority_req = '0;
  logic [9:0] in_slot_id = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_status;
  logic [9:0] out_result_slot;
  logic [1:0] out_result_cpu;
  logic [2:0] out_result_priority;

  thread_table_free_list_ready_queues dut (.*);

  always #6 clk = ~clk;

  // Mirror of the block's state.
  logic       used_q [NSLOT];
  logic [1:0] cpu_q [NSLOT];
  logic [2:0] prio_q [NSLOT];
  logic [10:0] flink [NSLOT];
  logic [10:0] rlink [NSLOT];
  logic [10:0] fhead, ftail;
  logic [10:0] qhead [NQ];
  logic [10:0] qtail [NQ];

  op_item_t   pending_items[$];
  op_result_t expected_results[$];
  int  failures = 0;
  int  send_idle_pct = 30;
  int  recv_idle_pct = 69;
  int  hold_cycles = 0;
  bit  stim_done = 0;
  int  accepted = 0;

  function automatic void reset_tables();
    for (int i = 0; i < NSLOT; i++) begin
      used_q[i] = (i < 4);
      cpu_q[i] = (i < 4) ? 2'(i) : 2'd0;
      prio_q[i] = '0;
      flink[i] = (i < 4 || i == NSLOT - 1) ? NIL : 11'(i + 1);
      rlink[i] = NIL;
    end
    for (int q = 0; q < NQ; q++) begin
      qhead[q] = NIL;
      qtail[q] = NIL;
    end
    for (int c = 0; c < 4; c++) begin
      qhead[c * 8] = 11'(c);
      qtail[c * 8] = 11'(c);
    end
    fhead = 11'd4;
    ftail = 11'(NSLOT - 1);
  endfunction

  function automatic op_result_t apply_op(op_item_t it);
    op_result_t r;
    int q;
    logic [10:0] s;
    r = '{ST_OK, 10'd0, 2'd0, 3'd0};
    case (it.mode)
      MODE_ALLOC: begin
        if (fhead == NIL) r.status = ST_NO_FREE;
        else begin
          s = fhead;
          fhead = flink[s];
          if (fhead == NIL) ftail = NIL;
          used_q[s] = 1'b1;
          cpu_q[s] = it.cpu;
          prio_q[s] = it.prio;
          flink[s] = NIL;
          rlink[s] = NIL;
          r = '{ST_OK, s[9:0], it.cpu, it.prio};
        end
      end
      MODE_FREE: begin
        if (!used_q[it.slot]) r.status = ST_NOT_USED;
        else begin
          used_q[it.slot] = 1'b0;
          flink[it.slot] = NIL;
          if (ftail == NIL || fhead == NIL) fhead = {1'b0, it.slot};
          else flink[ftail] = {1'b0, it.slot};
          ftail = {1'b0, it.slot};
        end
      end
      MODE_LOOKUP: begin
        if (!used_q[it.slot]) r.status = ST_NOT_USED;
        else r = '{ST_OK, it.slot, cpu_q[it.slot], prio_q[it.slot]};
      end
      MODE_ADMIT: begin
        if (!used_q[it.slot]) r.status = ST_NOT_USED;
        else begin
          q = cpu_q[it.slot] * 8 + prio_q[it.slot];
          if (qtail[q] == NIL) qhead[q] = {1'b0, it.slot};
          else rlink[qtail[q]] = {1'b0, it.slot};
          qtail[q] = {1'b0, it.slot};
        end
      end
      MODE_DISPATCH: begin
        q = it.cpu * 8 + it.prio;
        s = qhead[q];
        if (s == NIL) r.status = ST_EMPTY;
        else begin
          qhead[q] = rlink[s];
          if (qhead[q] == NIL) qtail[q] = NIL;
          rlink[s] = NIL;
          r = '{ST_OK, s[9:0], cpu_q[s], prio_q[s]};
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Driver: the head item stays on the port until taken, then leaves the queue.
  always @(posedge clk) begin
    if (rst_n) begin
      op_item_t it;
      if (in_valid && !in_stall) begin
        expected_results.push_back(apply_op('{in_mode, in_cpu, in_priority_req, in_slot_id}));
        accepted++;
        void'(pending_items.pop_front());
      end
      if (!in_valid || !in_stall) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          it = pending_items[0];
          in_valid <= 1'b1;
          in_mode <= it.mode;
          in_cpu <= it.cpu;
          in_priority_req <= it.prio;
          in_slot_id <= it.slot;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor and receiver stall.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result with nothing expected: status %0d", out_status);
          failures++;
        end else begin
          op_result_t e;
          e = expected_results.pop_front();
          if (out_status != e.status) begin
            $error("status expected %0d actual %0d", e.status, out_status);
            failures++;
          end
          if (out_result_slot != e.slot) begin
            $error("result_slot expected %0d actual %0d", e.slot, out_result_slot);
            failures++;
          end
          if (out_result_cpu != e.cpu) begin
            $error("result_cpu expected %0d actual %0d", e.cpu, out_result_cpu);
            failures++;
          end
          if (out_result_priority != e.prio) begin
            $error("result_priority expected %0d actual %0d", e.prio, out_result_priority);
            failures++;
          end
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  function automatic op_item_t rand_item();
    op_item_t it;
    int r;
    it.cpu = 2'($urandom);
    it.prio = 3'($urandom_range(0, 2)) | (($urandom_range(9) == 0) ? 3'($urandom) : 3'd0);
    r = $urandom_range(99);
    if (r < 25) it.mode = MODE_ALLOC;
    else if (r < 40) it.mode = MODE_FREE;
    else if (r < 55) it.mode = MODE_LOOKUP;
    else if (r < 75) it.mode = MODE_ADMIT;
    else if (r < 97) it.mode = MODE_DISPATCH;
    else it.mode = 3'($urandom_range(5, 7));
    // Mostly slots near the allocated range, sometimes anywhere.
    it.slot = ($urandom_range(9) == 0) ? 10'($urandom) : 10'($urandom_range(0, 40));
    return it;
  endfunction

  task automatic drain();
    while (pending_items.size() > 0 || expected_results.size() > 0) @(posedge clk);
  endtask

  initial begin
    op_item_t it;
    reset_tables();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    // Directed: every mode, extremes and error paths.
    pending_items.push_back('{MODE_LOOKUP, 2'd0, 3'd0, 10'd3});
    pending_items.push_back('{MODE_LOOKUP, 2'd0, 3'd0, 10'd1023});
    pending_items.push_back('{MODE_DISPATCH, 2'd3, 3'd0, 10'd0});
    pending_items.push_back('{MODE_DISPATCH, 2'd3, 3'd7, 10'd0});
    pending_items.push_back('{MODE_ALLOC, 2'd3, 3'd7, 10'd1023});
    pending_items.push_back('{MODE_LOOKUP, 2'd0, 3'd0, 10'd4});
    pending_items.push_back('{MODE_ADMIT, 2'd0, 3'd0, 10'd4});
    pending_items.push_back('{MODE_ADMIT, 2'd0, 3'd0, 10'd4});
    pending_items.push_back('{MODE_DISPATCH, 2'd3, 3'd7, 10'd0});
    pending_items.push_back('{MODE_DISPATCH, 2'd3, 3'd7, 10'd0});
    pending_items.push_back('{MODE_FREE, 2'd0, 3'd0, 10'd4});
    pending_items.push_back('{MODE_FREE, 2'd0, 3'd0, 10'd4});
    pending_items.push_back('{MODE_ADMIT, 2'd0, 3'd0, 10'd500});
    pending_items.push_back('{MODE_LOOKUP, 2'd0, 3'd0, 10'd1023});
    pending_items.push_back('{3'd5, 2'd3, 3'd7, 10'd1023});
    pending_items.push_back('{3'd7, 2'd0, 3'd0, 10'd0});
    pending_items.push_back('{MODE_FREE, 2'd0, 3'd0, 10'd0});
    pending_items.push_back('{MODE_DISPATCH, 2'd0, 3'd0, 10'd0});
    drain();
    // Exhaust the free list, then free into an empty list.
    for (int i = 0; i < 1021; i++) pending_items.push_back('{MODE_ALLOC, 2'($urandom), 3'($urandom), 10'd0});
    pending_items.push_back('{MODE_ALLOC, 2'd1, 3'd1, 10'd0});
    pending_items.push_back('{MODE_FREE, 2'd0, 3'd0, 10'd777});
    pending_items.push_back('{MODE_ALLOC, 2'd2, 3'd5, 10'd0});
    pending_items.push_back('{MODE_FREE, 2'd0, 3'd0, 10'd1023});
    pending_items.push_back('{MODE_FREE, 2'd0, 3'd0, 10'd512});
    // Long receiver hold while the sender keeps offering.
    hold_cycles = 200;
    for (int phase = 0; phase < 3; phase++) begin
      drain();
      send_idle_pct = (phase == 0) ? 30 : (phase == 1) ? 69 : 0;
      recv_idle_pct = (phase == 0) ? 69 : (phase == 1) ? 30 : 0;
      for (int i = 0; i < 60; i++) pending_items.push_back(rand_item());
    end
    drain();
    repeat (20) @(posedge clk);
    if (failures == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #3000000;
    $display("*** FAILED ***");
    $finish;
  end
endmodule

>>> filelist.f
hw/rtl/ttq_pkg.sv
hw/rtl/ttq_front.sv
hw/rtl/ttq_back.sv
hw/rtl/thread_table_free_list_ready_queues.sv
sim/tb_thread_table_free_list_ready_queues.sv
